// ----- src/b2da_pkg.sv -----
// Package: shared constants, types and controller states for the decimal ASCII converter.
package b2da_pkg;

  // Number of decimal digits needed for the largest value of a given width
  function automatic int dec_digits(input int bits);
    longint unsigned v;
    int n;
    v = (longint'(1) << bits) - 1;
    n = 0;
    while (v != 0) begin
      v = v / 10;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int VALUE_WIDTH = 16;
  localparam int DIGITS      = dec_digits(VALUE_WIDTH);
  localparam int BCD_W       = DIGITS * 4;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  localparam int PTR_W       = $clog2(DIGITS);
  localparam int CHAR_W      = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_FIND,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture input word, clear BCD
    logic shift;  // one shift-add-3 step
    logic find;   // latch leading digit position
    logic step;   // move to next lower digit
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bits_done;  // current shift is the final one
    logic ptr_zero;   // pointing at least significant digit
  } status_t;

endpackage

// ----- src/b2da_dpath.sv -----
// Datapath: shift-add-3 binary to BCD converter and digit readout pointer.
module b2da_dpath (
  input  logic                             clk,
  input  logic [b2da_pkg::VALUE_WIDTH-1:0] value,
  input  b2da_pkg::cmd_t                   cmd,
  output b2da_pkg::status_t                status,
  output logic [b2da_pkg::CHAR_W-1:0]      digit_char
);

  logic [b2da_pkg::VALUE_WIDTH-1:0] shreg;
  logic [b2da_pkg::BCD_W-1:0]       bcd;
  logic [b2da_pkg::BCD_W-1:0]       adj;
  logic [b2da_pkg::CNT_W-1:0]       cnt;
  logic [b2da_pkg::PTR_W-1:0]       ptr;
  logic [b2da_pkg::PTR_W-1:0]       lead;
  logic [3:0]                       cur;

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  // Highest nonzero digit; zero value leaves position 0
  always_comb begin
    lead = '0;
    for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        lead = b2da_pkg::PTR_W'(i);
      end
    end
  end

  // Conversion and readout registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg <= value;
      bcd   <= '0;
      cnt   <= b2da_pkg::CNT_W'(b2da_pkg::VALUE_WIDTH - 1);
    end else if (cmd.shift) begin
      {bcd, shreg} <= {adj[b2da_pkg::BCD_W-2:0], shreg, 1'b0};
      cnt          <= cnt - 1'b1;
    end
    if (cmd.find) begin
      ptr <= lead;
    end else if (cmd.step) begin
      ptr <= ptr - 1'b1;
    end
  end

  assign cur              = bcd[ptr*4 +: 4];
  assign digit_char       = b2da_pkg::ASCII_ZERO + {2'b00, cur};
  assign status.bits_done = (cnt == '0);
  assign status.ptr_zero  = (ptr == '0);

endmodule

// ----- src/b2da_ctrl.sv -----
// Controller: sequences load, conversion, leading digit search and digit output.
module b2da_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  b2da_pkg::status_t       status,
  output b2da_pkg::cmd_t          cmd
);

  b2da_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= b2da_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      b2da_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = b2da_pkg::ST_CONVERT;
        end
      end
      b2da_pkg::ST_CONVERT: begin
        cmd.shift = 1'b1;
        if (status.bits_done) begin
          state_next = b2da_pkg::ST_FIND;
        end
      end
      b2da_pkg::ST_FIND: begin
        cmd.find   = 1'b1;
        state_next = b2da_pkg::ST_EMIT;
      end
      b2da_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.ptr_zero) begin
            state_next = b2da_pkg::ST_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_next = b2da_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/binary_to_decimal_ascii_core.sv -----
// Top level: unsigned binary word to ASCII decimal digits, most significant first.
//
//   channel | signals                          | direction
//   input   | in_valid, in_ready, value        | word in
//   output  | out_valid, out_ready, digit_char, | one digit word out,
//           | last_digit                       | last_digit on final one
//
// A word is loaded, run through VALUE_WIDTH shift-add-3 steps (16 at the
// default width), its leading digit is located, then its digits (1 to 5) go
// out one per cycle while out_ready is high. The single shift-add-3 unit does every step.
// in_ready is high only while idle. A stalled output holds its digit.
// Reset clears the controller only; zero is sent as a single '0'.
module binary_to_decimal_ascii_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [b2da_pkg::VALUE_WIDTH-1:0] value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]      digit_char,
  output logic                             last_digit
);

  b2da_pkg::cmd_t    cmd;
  b2da_pkg::status_t status;

  b2da_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  b2da_dpath u_dpath (
    .clk        (clk),
    .value      (value),
    .cmd        (cmd),
    .status     (status),
    .digit_char (digit_char)
  );

  assign last_digit = status.ptr_zero;

endmodule

// ----- src/b2da_check.sv -----
// Checker: port level properties of the converter, bound to the top level.
module b2da_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [b2da_pkg::CHAR_W-1:0] digit_char,
  input logic                        last_digit
);

  // Only one word in flight: never taking input while digits are pending
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while digits pending");

  // Digits of a word follow back to back
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_digit) |=> out_valid)
    else $error("digit run broken before last digit");

  // Only decimal digit characters appear
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_char >= 6'd48 && digit_char <= 6'd57))
    else $error("non-digit character");

  // Conversion needs time after accepting a word
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("output too soon after input");

  // Stalled digit holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(digit_char) && $stable(last_digit)))
    else $error("stalled digit changed");

endmodule

bind binary_to_decimal_ascii_core b2da_check u_b2da_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .digit_char (digit_char),
  .last_digit (last_digit)
);

// ----- dv/tb_top.sv -----
// Testbench for binary_to_decimal_ascii_core: random and directed words, digit-by-digit checking.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF = 4;
  localparam int RAND_PER_PHASE = 115;
  localparam int TAIL_CYCLES = 40;

  // One expected output digit word
  typedef struct {
    logic [b2da_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } digit_t;

  // One pending input word with its pacing
  typedef struct {
    logic [b2da_pkg::VALUE_WIDTH-1:0] val;
    int unsigned                      tx_idle;  // percent of cycles sender holds off
    int unsigned                      rx_stall; // percent of cycles receiver stalls
    bit                               drain;    // wait for all digits before sending
  } word_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [b2da_pkg::VALUE_WIDTH-1:0] value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [b2da_pkg::CHAR_W-1:0]      digit_char;
  logic                             last_digit;

  word_t       pending_words[$];
  digit_t      expected_digits[$];
  int unsigned rx_stall_pct = 0;
  int          error_count = 0;

  binary_to_decimal_ascii_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  always #CLK_HALF clk = ~clk;

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Queue the decimal digits of v, most significant first, last flag on the final one
  task automatic predict_digits(input logic [b2da_pkg::VALUE_WIDTH-1:0] v);
    int unsigned n;
    int unsigned rev[$];
    digit_t      d;
    n = 32'(v);
    do begin
      rev.push_front(n % 10);
      n = n / 10;
    end while (n != 0);
    foreach (rev[k]) begin
      d.ch   = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(rev[k]);
      d.last = (k == rev.size() - 1);
      expected_digits.push_back(d);
    end
  endtask

  task automatic add_word(input logic [b2da_pkg::VALUE_WIDTH-1:0] v, input int unsigned tx,
                          input int unsigned rx, input bit drain);
    word_t w;
    w.val      = v;
    w.tx_idle  = tx;
    w.rx_stall = rx;
    w.drain    = drain;
    pending_words.push_back(w);
  endtask

  // Random value, mostly with a chosen digit count so every length is hit
  function automatic logic [b2da_pkg::VALUE_WIDTH-1:0] rand_value();
    int unsigned nd;
    int unsigned lo;
    int unsigned hi;
    if ($urandom_range(3) == 0) return b2da_pkg::VALUE_WIDTH'($urandom);
    nd = $urandom_range(1, 5);
    lo = (nd == 1) ? 0 : 10 ** (nd - 1);
    hi = (10 ** nd) - 1;
    if (hi > 65535) hi = 65535;
    return b2da_pkg::VALUE_WIDTH'($urandom_range(hi, lo));
  endfunction

  // Driver: presents pending words, records expected digits on acceptance
  always @(posedge clk) begin : drv
    logic nv;
    if (rst) begin
      in_valid <= 1'b0;
      value    <= '0;
    end else begin
      if (in_valid && in_ready) predict_digits(value);
      if (!in_valid || in_ready) begin
        nv = 1'b0;
        if (pending_words.size() != 0) begin
          if (pending_words[0].drain && expected_digits.size() != 0) begin
            nv = 1'b0;
          end else if ($urandom_range(99) < pending_words[0].tx_idle) begin
            nv = 1'b0;
          end else begin
            nv = 1'b1;
            value        <= pending_words[0].val;
            rx_stall_pct <= pending_words[0].rx_stall;
            void'(pending_words.pop_front());
          end
        end
        in_valid <= nv;
      end
    end
  end

  // Monitor: compares each accepted digit word with the oldest expectation
  always @(posedge clk) begin : mon
    digit_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          report_mismatch("unexpected digit", int'(digit_char), -1);
        end else begin
          want = expected_digits.pop_front();
          if (digit_char !== want.ch) begin
            report_mismatch("digit_char", int'(digit_char), int'(want.ch));
          end
          if (last_digit !== want.last) begin
            report_mismatch("last_digit", int'(last_digit), int'(want.last));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Stimulus and end of run
  initial begin : stim
    int unsigned tx_pct[4];
    int unsigned rx_pct[4];
    tx_pct = '{0, 70, 0, 18};
    rx_pct = '{0, 0, 70, 18};

    // Directed: zero, extremes, digit-count boundaries, alternating bits
    add_word(16'd0, 0, 0, 1'b0);
    add_word(16'd1, 0, 0, 1'b0);
    add_word(16'd9, 0, 0, 1'b0);
    add_word(16'd10, 0, 0, 1'b0);
    add_word(16'd99, 0, 0, 1'b0);
    add_word(16'd100, 0, 0, 1'b0);
    add_word(16'd999, 0, 0, 1'b0);
    add_word(16'd1000, 0, 0, 1'b0);
    add_word(16'd9999, 0, 0, 1'b0);
    add_word(16'd10000, 0, 0, 1'b0);
    add_word(16'd65535, 0, 0, 1'b0);
    add_word(16'd65534, 0, 0, 1'b0);
    add_word(16'd32768, 0, 0, 1'b0);
    add_word(16'h5555, 0, 0, 1'b0);
    add_word(16'hAAAA, 0, 0, 1'b0);
    add_word(16'd12345, 0, 0, 1'b0);
    add_word(16'd10009, 0, 0, 1'b0);
    add_word(16'd60000, 0, 0, 1'b0);
    add_word(16'd0, 0, 0, 1'b0);
    add_word(16'd1, 0, 0, 1'b0);

    // Random: one run per idling phase, opening and again halfway after a full drain
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        add_word(rand_value(), tx_pct[p], rx_pct[p], (i == 0) || (i == RAND_PER_PHASE / 2));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
src/b2da_pkg.sv
src/b2da_dpath.sv
src/b2da_ctrl.sv
src/binary_to_decimal_ascii_core.sv
src/b2da_check.sv
dv/tb_top.sv
